FILE: rtl/tpt_pkg.sv
`default_nettype none

package tpt_pkg;

    localparam int TASK_SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_EDIT   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_EXEC   = 2'd3
    } func_e_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] task_id;
        logic [15:0] user_id;
        logic [15:0] priority_req;
    } tpt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_user;
    } tpt_out_t;

    // one table slot with its valid bit
    typedef struct packed {
        logic        vld;
        logic [15:0] tid;
        logic [15:0] uid;
        logic [15:0] prio;
    } tpt_entry_t;

    typedef enum logic [2:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_DRAIN,
        CTRL_COMMIT
    } tpt_state_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic commit;
    } tpt_cmd_t;

    typedef struct packed {
        logic out_free;
    } tpt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/tpt_datapath.sv
`default_nettype none

module tpt_datapath #(
    parameter int TASK_SLOTS = tpt_pkg::TASK_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tpt_pkg::tpt_cmd_t             cmd,
    input  wire logic [$clog2(TASK_SLOTS)-1:0] addr,
    output tpt_pkg::tpt_sts_t                  sts,
    input  wire tpt_pkg::tpt_in_t              req,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tpt_pkg::tpt_out_t                  m_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    tpt_pkg::tpt_entry_t mem [TASK_SLOTS];

    tpt_pkg::tpt_entry_t rd_data_reg;
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    tpt_pkg::tpt_in_t    req_reg;

    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [15:0]         match_uid_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                best_found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [15:0]         best_prio_reg;
    logic [15:0]         best_tid_reg;
    logic [15:0]         best_uid_reg;

    logic                m_valid_reg;
    tpt_pkg::tpt_out_t   m_data_reg;

    logic                hit_match;
    logic                hit_free;
    logic                hit_best;

    logic                wr_hit;
    logic [IDX_W-1:0]    wr_sel;
    tpt_pkg::tpt_entry_t wr_entry;
    tpt_pkg::tpt_out_t   result;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    tpt_pkg::tpt_entry_t wr_data;

    // compare of the slot read in the previous cycle
    always_comb begin
        hit_match = rd_valid_reg && rd_data_reg.vld && (rd_data_reg.tid == req_reg.task_id)
                    && !match_found_reg;
        hit_free  = rd_valid_reg && !rd_data_reg.vld && !free_found_reg;
        hit_best  = rd_valid_reg && rd_data_reg.vld &&
                    (!best_found_reg || (rd_data_reg.prio > best_prio_reg) ||
                     ((rd_data_reg.prio == best_prio_reg) && (rd_data_reg.tid > best_tid_reg)));
    end

    // decision once the sweep is over
    always_comb begin
        wr_hit             = 1'b0;
        wr_sel             = match_idx_reg;
        wr_entry.vld       = 1'b1;
        wr_entry.tid       = req_reg.task_id;
        wr_entry.uid       = req_reg.user_id;
        wr_entry.prio      = req_reg.priority_req;
        result.status      = tpt_pkg::ST_OK;
        result.served_user = 16'd0;
        unique case (tpt_pkg::func_e_t'(req_reg.func))
            tpt_pkg::FUNC_ADD: begin
                if (match_found_reg) begin
                    wr_hit = 1'b1;
                end else if (free_found_reg) begin
                    wr_hit = 1'b1;
                    wr_sel = free_idx_reg;
                end else begin
                    result.status = tpt_pkg::ST_FULL;
                end
            end
            tpt_pkg::FUNC_EDIT: begin
                wr_entry.uid = match_uid_reg;
                if (match_found_reg) begin
                    wr_hit = 1'b1;
                end else begin
                    result.status = tpt_pkg::ST_MISS;
                end
            end
            tpt_pkg::FUNC_REMOVE: begin
                wr_entry.vld = 1'b0;
                if (match_found_reg) begin
                    wr_hit = 1'b1;
                end else begin
                    result.status = tpt_pkg::ST_MISS;
                end
            end
            tpt_pkg::FUNC_EXEC: begin
                wr_entry.vld = 1'b0;
                wr_sel       = best_idx_reg;
                if (best_found_reg) begin
                    wr_hit             = 1'b1;
                    result.served_user = best_uid_reg;
                end else begin
                    result.status = tpt_pkg::ST_MISS;
                end
            end
            default: begin
                wr_hit = 1'b0;
            end
        endcase
    end

    // single write port shared by the clearing sweep and the commit
    always_comb begin
        wr_en   = cmd.clr_wr || (cmd.commit && wr_hit);
        wr_addr = cmd.clr_wr ? addr : wr_sel;
        wr_data = wr_entry;
        if (cmd.clr_wr) begin
            wr_data     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd;
            if (cmd.load) begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                best_found_reg  <= 1'b0;
            end else begin
                if (hit_match) begin
                    match_found_reg <= 1'b1;
                end
                if (hit_free) begin
                    free_found_reg <= 1'b1;
                end
                if (hit_best) begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= addr;
        if (cmd.load) begin
            req_reg <= req;
        end
        if (hit_match) begin
            match_idx_reg <= rd_idx_reg;
            match_uid_reg <= rd_data_reg.uid;
        end
        if (hit_free) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (hit_best) begin
            best_idx_reg  <= rd_idx_reg;
            best_prio_reg <= rd_data_reg.prio;
            best_tid_reg  <= rd_data_reg.tid;
            best_uid_reg  <= rd_data_reg.uid;
        end
        if (cmd.commit) begin
            m_data_reg <= result;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/tpt_ctrl.sv
`default_nettype none

module tpt_ctrl #(
    parameter int TASK_SLOTS = tpt_pkg::TASK_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    output tpt_pkg::tpt_cmd_t                  cmd,
    output logic [$clog2(TASK_SLOTS)-1:0]      addr,
    input  wire tpt_pkg::tpt_sts_t             sts
);

    localparam int               IDX_W = $clog2(TASK_SLOTS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(TASK_SLOTS - 1);

    tpt_pkg::tpt_state_t state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpt_pkg::CTRL_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        addr       = cnt_reg;
        unique case (state_reg)
            tpt_pkg::CTRL_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = tpt_pkg::CTRL_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tpt_pkg::CTRL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = tpt_pkg::CTRL_SCAN;
                end
            end
            tpt_pkg::CTRL_SCAN: begin
                cmd.rd = 1'b1;
                if (cnt_reg == LAST) begin
                    state_next = tpt_pkg::CTRL_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tpt_pkg::CTRL_DRAIN: begin
                state_next = tpt_pkg::CTRL_COMMIT;
            end
            tpt_pkg::CTRL_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = tpt_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = tpt_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/task_priority_table_core.sv
`default_nettype none

// indexed max-priority task table: each input transfer is one operation (add, edit
// priority, remove, execute top) and gives exactly one result transfer. every
// operation sweeps the whole slot memory once through its single read port, one slot
// per cycle, and its result is loaded into the output register once that register is
// free or being taken by m_ready; the next input is taken in the cycle after the
// previous result is loaded into the output register, even while that result still
// waits. after reset a clearing sweep over all TASK_SLOTS slots marks every slot free,
// and s_ready stays low during it. add overwrites an existing id or takes the lowest
// free slot (status 2 when full); edit and remove of a missing id, and execute top on
// an empty table, give status 1. execute top picks the highest priority, ties going
// to the highest task id.

module task_priority_table_core #(
    parameter int TASK_SLOTS = tpt_pkg::TASK_SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // operation input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tpt_pkg::tpt_in_t  s_data,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tpt_pkg::tpt_out_t      m_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    // command and status between sequencer and datapath
    tpt_pkg::tpt_cmd_t cmd;
    tpt_pkg::tpt_sts_t sts;
    logic [IDX_W-1:0]  addr;

    // sequencer: clearing sweep, request capture, slot sweep, commit
    tpt_ctrl #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .addr    (addr),
        .sts     (sts)
    );

    // slot memory, match / free / top trackers, output register
    tpt_datapath #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .addr    (addr),
        .sts     (sts),
        .req     (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
